@@ hw/rtl/aesks_pkg.sv @@
// AES-128 key schedule package: S-box table, round constant helpers,
// byte-serial control bundle. No dependencies.
package aesks_pkg;

  typedef logic [7:0] byte_t;

  // Number of rounds after the initial key
  localparam int unsigned ROUNDS    = 10;
  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned BYTE_CNT_W = $clog2(KEY_BYTES);
  localparam int unsigned ROUND_W    = 4;

  localparam byte_t RCON_INIT = 8'h01;
  localparam byte_t RCON_POLY = 8'h1B;

  // Controls from the sequencer to the byte datapath
  typedef struct packed {
    logic load;        // take a new key
    logic shift;       // process one byte and rotate
    logic first_byte;  // byte 0 of the round
    logic row_start;   // first byte of a row
    logic last_row;    // bytes of row 3
  } aesks_ctrl_t;

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiply by x in GF(2^8)
  function automatic byte_t xtime(byte_t v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? RCON_POLY : 8'h00);
  endfunction

endpackage

@@ hw/rtl/aes128_key_expansion_unit.sv @@
// AES-128 key expansion top level: sequencer and output register around the
// byte-serial datapath. Depends on aesks_pkg and aesks_byte_path.
// Round 0 is published once the key is accepted; each later round key is
// published after 16 byte steps through the one S-box, and later while an
// output stall holds the previous one. The next key is taken once round 10
// is published.
// Reset (synchronous, rst_n low) returns to idle with no result pending.
module aes128_key_expansion_unit
  import aesks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         in_key_high,
  input  logic [63:0]         in_key_low,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ROUND_W-1:0]  out_round_index,
  output logic [63:0]         out_round_key_high,
  output logic [63:0]         out_round_key_low,
  output logic                out_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ROUND_W-1:0]    round_r, round_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROUND_W-1:0]    out_round_r;
  logic [127:0]          out_key_r;
  logic                  out_last_r;
  logic                  out_free;
  logic                  publish;
  logic                  last_round;
  aesks_ctrl_t           ctrl;
  logic [127:0]          work_key;

  assign out_free   = !out_valid_r || !out_stall;
  assign last_round = (round_r == ROUND_W'(ROUNDS));
  assign publish    = (state_r == ST_EMIT) && out_free;
  assign in_stall   = (state_r != ST_IDLE);

  // Decode the byte position for the datapath
  always_comb begin
    ctrl.load       = (state_r == ST_IDLE) && in_valid;
    ctrl.shift      = (state_r == ST_CALC);
    ctrl.first_byte = (cnt_r == '0);
    ctrl.row_start  = (cnt_r[1:0] == 2'd0);
    ctrl.last_row   = (cnt_r[3:2] == 2'd3);
  end

  aesks_byte_path u_byte_path (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .key_in  ({in_key_high, in_key_low}),
    .key_out (work_key)
  );

  // Sequence: load, publish round key, run 16 byte steps, repeat
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    round_nxt = round_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          round_nxt = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_round) begin
            state_nxt = ST_IDLE;
          end else begin
            round_nxt = round_r + 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      round_r <= round_nxt;
    end
  end

  // Hold the published item until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_round_r <= round_r;
      out_key_r   <= work_key;
      out_last_r  <= last_round;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_round_index    = out_round_r;
  assign out_round_key_high = out_key_r[127:64];
  assign out_round_key_low  = out_key_r[63:0];
  assign out_last           = out_last_r;

endmodule

@@ hw/rtl/aesks_byte_path.sv @@
// Byte-serial round datapath: 16-byte rotating key register, one S-box
// lookup per cycle while shifting, plus XORs for the new byte. Depends on aesks_pkg.
module aesks_byte_path
  import aesks_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  aesks_ctrl_t  ctrl,
  input  logic [127:0] key_in,
  output logic [127:0] key_out
);

  byte_t sr_r [KEY_BYTES];
  byte_t sr_nxt [KEY_BYTES];
  byte_t prev_r;
  byte_t save_r;
  byte_t rcon_r;
  byte_t rcon_nxt;
  byte_t sbox_in;
  byte_t sbox_out;
  byte_t new_byte;

  // Substitute the last byte of the next row; row 3 wraps to the saved byte 3
  always_comb begin
    sbox_in  = ctrl.last_row ? save_r : sr_r[7];
    sbox_out = SBOX[sbox_in];
    if (ctrl.row_start) begin
      new_byte = sr_r[0] ^ sbox_out ^ (ctrl.first_byte ? rcon_r : 8'h00);
    end else begin
      new_byte = sr_r[0] ^ prev_r;
    end
  end

  // Load or rotate the key bytes
  always_comb begin
    for (int j = 0; j < KEY_BYTES; j++) begin
      sr_nxt[j] = sr_r[j];
    end
    if (ctrl.load) begin
      for (int j = 0; j < KEY_BYTES; j++) begin
        sr_nxt[j] = key_in[127 - 8*j -: 8];
      end
    end else if (ctrl.shift) begin
      for (int j = 0; j < KEY_BYTES - 1; j++) begin
        sr_nxt[j] = sr_r[j + 1];
      end
      sr_nxt[KEY_BYTES - 1] = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < KEY_BYTES; j++) begin
      sr_r[j] <= sr_nxt[j];
    end
    if (ctrl.shift) begin
      prev_r <= new_byte;
      if (ctrl.first_byte) begin
        save_r <= sr_r[3];
      end
    end
  end

  // Advance the round constant once per round
  always_comb begin
    rcon_nxt = rcon_r;
    if (ctrl.load) begin
      rcon_nxt = RCON_INIT;
    end else if (ctrl.shift && ctrl.first_byte) begin
      rcon_nxt = xtime(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcon_r <= RCON_INIT;
    end else begin
      rcon_r <= rcon_nxt;
    end
  end

  always_comb begin
    for (int j = 0; j < KEY_BYTES; j++) begin
      key_out[127 - 8*j -: 8] = sr_r[j];
    end
  end

endmodule
